// ----- hw/rtl/utf8d_pkg.sv -----
package utf8d_pkg;

    // Unit emitted for an invalid or incomplete byte ('?')
    localparam logic [15:0] REPL_UNIT = 16'h003F;

    // Sequence lengths opened by a lead byte
    localparam logic [2:0] LEN2 = 3'd2;
    localparam logic [2:0] LEN3 = 3'd3;
    localparam logic [2:0] LEN4 = 3'd4;

    // Most replacement units one byte can cause (three held plus one flushed lead)
    localparam logic [2:0] MAX_REPL = 3'd4;

    // Open multi-byte sequence
    typedef struct packed {
        logic [1:0]  pend_cnt;
        logic [2:0]  seq_len;
        logic [15:0] partial;
    } seq_state_t;

    // Results caused by one byte: rep_cnt replacements, then an optional main unit
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic        main_vld;
        logic [15:0] main_unit;
        logic        main_repl;
        logic        end_flag;
    } burst_t;

endpackage

// ----- hw/rtl/utf8d_decode.sv -----
module utf8d_decode import utf8d_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output burst_t     burst,
    output seq_state_t state
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_state_t  mid_state;
    seq_state_t  fresh_state;
    logic        fresh_vld;
    logic [15:0] fresh_unit;
    logic        fresh_repl;
    logic        is_cont;
    logic [2:0]  held;
    logic [15:0] merged;
    logic [1:0]  pre_cnt;
    logic [1:0]  post_cnt;

    // Decode a byte as if no sequence were open
    always_comb begin
        fresh_state = '0;
        fresh_vld   = 1'b0;
        fresh_unit  = REPL_UNIT;
        fresh_repl  = 1'b1;
        if (in_byte[7:3] == 5'b11110) begin
            fresh_state.pend_cnt = 2'd1;
            fresh_state.seq_len  = LEN4;
            fresh_state.partial  = {13'd0, in_byte[2:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
            fresh_state.pend_cnt = 2'd1;
            fresh_state.seq_len  = LEN3;
            fresh_state.partial  = {12'd0, in_byte[3:0]};
        end else if (in_byte[7:5] == 3'b110) begin
            fresh_state.pend_cnt = 2'd1;
            fresh_state.seq_len  = LEN2;
            fresh_state.partial  = {11'd0, in_byte[4:0]};
        end else if (!in_byte[7]) begin
            fresh_vld  = 1'b1;
            fresh_unit = {8'd0, in_byte};
            fresh_repl = 1'b0;
        end else begin
            // stray continuation or F8..FF
            fresh_vld = 1'b1;
        end
    end

    // Continue an open sequence, or break it and decode afresh
    always_comb begin
        is_cont         = (in_byte[7:6] == 2'b10);
        held            = {1'b0, state_reg.pend_cnt} + 3'd1;
        merged          = {state_reg.partial[9:0], in_byte[5:0]};
        mid_state       = fresh_state;
        pre_cnt         = state_reg.pend_cnt;
        burst.main_vld  = fresh_vld;
        burst.main_unit = fresh_unit;
        burst.main_repl = fresh_repl;
        if ((state_reg.pend_cnt != 2'd0) && is_cont) begin
            pre_cnt = 2'd0;
            if (held >= state_reg.seq_len) begin
                mid_state       = '0;
                burst.main_vld  = 1'b1;
                burst.main_unit = merged;
                burst.main_repl = 1'b0;
            end else begin
                mid_state.pend_cnt = held[1:0];
                mid_state.seq_len  = state_reg.seq_len;
                mid_state.partial  = merged;
                burst.main_vld     = 1'b0;
            end
        end
        // end of string flushes whatever is still held
        if (in_end) begin
            post_cnt   = mid_state.pend_cnt;
            state_next = '0;
        end else begin
            post_cnt   = 2'd0;
            state_next = mid_state;
        end
        burst.rep_cnt  = {1'b0, pre_cnt} + {1'b0, post_cnt};
        burst.end_flag = in_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- hw/rtl/utf8d_burst.sv -----
module utf8d_burst import utf8d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  burst_t      load_data,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_is_replacement,
    output logic        m_out_end
);

    burst_t burst_reg;
    burst_t burst_next;
    logic   busy;
    logic   last_unit;
    logic   pop;

    // Unit selection: replacements go out first, then the main unit
    always_comb begin
        busy      = (burst_reg.rep_cnt != 3'd0) || burst_reg.main_vld;
        last_unit = ((burst_reg.rep_cnt == 3'd1) && !burst_reg.main_vld)
                 || ((burst_reg.rep_cnt == 3'd0) && burst_reg.main_vld);
        pop       = busy && m_ready;
        free      = !busy || (m_ready && last_unit);
    end

    always_comb begin
        m_valid = busy;
        if (burst_reg.rep_cnt != 3'd0) begin
            m_code_unit      = REPL_UNIT;
            m_is_replacement = 1'b1;
        end else begin
            m_code_unit      = burst_reg.main_unit;
            m_is_replacement = burst_reg.main_repl;
        end
        m_out_end = burst_reg.end_flag && last_unit;
    end

    // Load a fresh burst, or count down one transfer
    always_comb begin
        burst_next = burst_reg;
        if (load) begin
            burst_next = load_data;
        end else if (pop) begin
            if (burst_reg.rep_cnt != 3'd0) begin
                burst_next.rep_cnt = burst_reg.rep_cnt - 3'd1;
            end else begin
                burst_next.main_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg <= '0;
        end else begin
            burst_reg <= burst_next;
        end
    end

endmodule

// ----- hw/rtl/utf8_to_ucs2_decoder_top.sv -----
// A byte taken in waits in the input register until the result register is free, then
// is loaded into the result register, which raises m_valid if the byte gives a unit.
// Throughput: one byte per cycle while each byte gives at most one unit and m_ready
// stays high; a byte giving k units (up to 4) holds the result register until all k are taken.
// Reset (aresetn low, synchronous) empties both registers and closes any sequence.
module utf8_to_ucs2_decoder_top import utf8d_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_is_replacement,
    output logic        m_out_end
);

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       burst_free;
    logic       load;
    burst_t     dec_burst;
    seq_state_t seq_state;

    // Input register hands over whenever the result register can take a burst
    always_comb begin
        load        = in_vld_reg && burst_free;
        s_ready     = !in_vld_reg || burst_free;
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (load) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_end_reg  <= s_in_end;
        end
    end

    utf8d_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (load),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .burst   (dec_burst),
        .state   (seq_state)
    );

    utf8d_burst u_burst (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .load_data        (dec_burst),
        .free             (burst_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_unit      (m_code_unit),
        .m_is_replacement (m_is_replacement),
        .m_out_end        (m_out_end)
    );

    // Checks
    a_repl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (dec_burst.rep_cnt <= MAX_REPL))
        else $error("replacement count out of range");

    a_open_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_state.pend_cnt != 2'd0) |->
            ((seq_state.seq_len >= LEN2) && (seq_state.seq_len <= LEN4)
             && ({1'b0, seq_state.pend_cnt} < seq_state.seq_len)))
        else $error("open sequence inconsistent");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_end_reg) |=> (seq_state.pend_cnt == 2'd0))
        else $error("sequence left open after end of string");

    a_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && in_end_reg) |-> ((dec_burst.rep_cnt != 3'd0) || dec_burst.main_vld))
        else $error("end of string byte gave no unit");

endmodule
